@@ src/secure_option_byte_parser_unit_defines.svh @@
// Assertion macros shared by the option byte parser checker.
// No dependencies; included by files that hold assertions.
`ifndef SECURE_OPTION_BYTE_PARSER_UNIT_DEFINES_SVH
`define SECURE_OPTION_BYTE_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define OBP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("option byte parser check failed");

// Next-cycle implication, off while reset is asserted.
`define OBP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("option byte parser check failed");

// Checks what must follow a cycle with reset asserted.
`define OBP_ASSERT_RST(lbl, clk, rstn, cons) \
    lbl: assert property (@(posedge clk) (!rstn) |=> (cons)) \
        else $error("option byte parser reset check failed");

`endif

@@ src/obp_pkg.sv @@
// Types, codes and helper functions for the option byte parser.
// No dependencies; used by obp_step and the top level.
package obp_pkg;

    localparam logic [2:0] MAX_PIV_BYTES     = 3'd5;
    localparam logic [7:0] MAX_CONTEXT_BYTES = 8'd8;
    localparam logic [7:0] MAX_KEY_ID_BYTES  = 8'd7;

    localparam logic [7:0] FLAG_RESERVED = 8'hE0;
    localparam logic [7:0] FLAG_CONTEXT  = 8'h10;
    localparam logic [7:0] FLAG_KEY_ID   = 8'h08;

    localparam int SEQ_BYTES = 5;
    localparam int SEQ_W     = 8 * SEQ_BYTES;

    typedef enum logic [2:0] {
        PH_FLAGS  = 3'd0,
        PH_PIV    = 3'd1,
        PH_CLEN   = 3'd2,
        PH_CTX    = 3'd3,
        PH_KID    = 3'd4,
        PH_EXCESS = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ROLE_FLAGS  = 3'd0,
        ROLE_PIV    = 3'd1,
        ROLE_CLEN   = 3'd2,
        ROLE_CTX    = 3'd3,
        ROLE_KID    = 3'd4,
        ROLE_EXCESS = 3'd5
    } role_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_RESERVED  = 3'd1,
        ERR_PIV_LONG  = 3'd2,
        ERR_PIV_SHORT = 3'd3,
        ERR_CONTEXT   = 3'd4,
        ERR_KEY_ID    = 3'd5,
        ERR_TRAILING  = 3'd6
    } err_t;

    typedef struct packed {
        logic             in_option;
        logic [7:0]       flag_bits;
        phase_t           phase;
        logic [7:0]       field_count;
        logic [7:0]       ctx_len;
        logic [7:0]       kid_count;
        err_t             first_err;
        logic [SEQ_W-1:0] seq;
    } state_t;

    typedef struct packed {
        role_t            role;
        logic [7:0]       index;
        logic [7:0]       value;
        logic             done;
        err_t             status;
        logic [2:0]       piv_len;
        logic [7:0]       ctx_len;
        logic [7:0]       kid_len;
        logic [SEQ_W-1:0] seq;
    } result_t;

    localparam state_t ST_RESET = '{
        in_option:   1'b0,
        flag_bits:   8'd0,
        phase:       PH_FLAGS,
        field_count: 8'd0,
        ctx_len:     8'd0,
        kid_count:   8'd0,
        first_err:   ERR_NONE,
        seq:         '0
    };

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'hFF) ? 8'hFF : v + 8'd1;
    endfunction

    function automatic phase_t phase_after_ctx(input logic [7:0] flags);
        return ((flags & FLAG_KEY_ID) != 8'd0) ? PH_KID : PH_EXCESS;
    endfunction

    function automatic phase_t phase_after_piv(input logic [7:0] flags);
        return ((flags & FLAG_CONTEXT) != 8'd0) ? PH_CLEN : phase_after_ctx(flags);
    endfunction

endpackage

@@ src/obp_step.sv @@
// Per-byte parse step: next parser state and the result item for one byte.
// Depends on obp_pkg.
module obp_step (
    input  obp_pkg::state_t  cur_st,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    input  logic             empty_option,
    output obp_pkg::state_t  nxt_st,
    output obp_pkg::result_t res
);

    always_comb begin
        obp_pkg::state_t st;
        logic [7:0]      fc_inc;
        st     = cur_st;
        fc_inc = cur_st.field_count + 8'd1;
        res    = '0;
        nxt_st = cur_st;

        if (empty_option) begin
            // A zero-length option drops any partial option in progress.
            res.done = 1'b1;
            nxt_st   = obp_pkg::ST_RESET;
        end else begin
            res.value = data_byte;
            res.role  = obp_pkg::ROLE_FLAGS;
            if (!cur_st.in_option) begin
                st           = obp_pkg::ST_RESET;
                st.in_option = 1'b1;
                st.flag_bits = data_byte;
                if ((data_byte & obp_pkg::FLAG_RESERVED) != 8'd0) begin
                    st.first_err = obp_pkg::ERR_RESERVED;
                    st.phase     = obp_pkg::PH_EXCESS;
                end else if (data_byte[2:0] > obp_pkg::MAX_PIV_BYTES) begin
                    st.first_err = obp_pkg::ERR_PIV_LONG;
                    st.phase     = obp_pkg::PH_EXCESS;
                end else if (data_byte[2:0] != 3'd0) begin
                    st.phase = obp_pkg::PH_PIV;
                end else begin
                    st.phase = obp_pkg::phase_after_piv(data_byte);
                end
            end else begin
                unique case (cur_st.phase)
                    obp_pkg::PH_PIV: begin
                        res.role  = obp_pkg::ROLE_PIV;
                        res.index = cur_st.field_count;
                        for (int i = 0; i < obp_pkg::SEQ_BYTES; i++) begin
                            if (cur_st.field_count == 8'(i)) begin
                                st.seq[8*i +: 8] = cur_st.seq[8*i +: 8] | data_byte;
                            end
                        end
                        if (fc_inc >= {5'd0, cur_st.flag_bits[2:0]}) begin
                            st.field_count = 8'd0;
                            st.phase       = obp_pkg::phase_after_piv(cur_st.flag_bits);
                        end else begin
                            st.field_count = fc_inc;
                        end
                    end
                    obp_pkg::PH_CLEN: begin
                        res.role       = obp_pkg::ROLE_CLEN;
                        st.ctx_len     = data_byte;
                        st.field_count = 8'd0;
                        if (data_byte > obp_pkg::MAX_CONTEXT_BYTES) begin
                            if (cur_st.first_err == obp_pkg::ERR_NONE) begin
                                st.first_err = obp_pkg::ERR_CONTEXT;
                            end
                            st.phase = obp_pkg::PH_EXCESS;
                        end else if (data_byte == 8'd0) begin
                            st.phase = obp_pkg::phase_after_ctx(cur_st.flag_bits);
                        end else begin
                            st.phase = obp_pkg::PH_CTX;
                        end
                    end
                    obp_pkg::PH_CTX: begin
                        res.role  = obp_pkg::ROLE_CTX;
                        res.index = cur_st.field_count;
                        if (fc_inc >= cur_st.ctx_len) begin
                            st.field_count = 8'd0;
                            st.phase       = obp_pkg::phase_after_ctx(cur_st.flag_bits);
                        end else begin
                            st.field_count = fc_inc;
                        end
                    end
                    obp_pkg::PH_KID: begin
                        res.role       = obp_pkg::ROLE_KID;
                        res.index      = cur_st.field_count;
                        st.field_count = obp_pkg::sat_inc(cur_st.field_count);
                        st.kid_count   = obp_pkg::sat_inc(cur_st.kid_count);
                        if (st.kid_count > obp_pkg::MAX_KEY_ID_BYTES &&
                            cur_st.first_err == obp_pkg::ERR_NONE) begin
                            st.first_err = obp_pkg::ERR_KEY_ID;
                        end
                    end
                    default: begin
                        res.role       = obp_pkg::ROLE_EXCESS;
                        res.index      = cur_st.field_count;
                        st.field_count = obp_pkg::sat_inc(cur_st.field_count);
                        st.phase       = obp_pkg::PH_EXCESS;
                        if (cur_st.first_err == obp_pkg::ERR_NONE) begin
                            st.first_err = obp_pkg::ERR_TRAILING;
                        end
                    end
                endcase
            end

            if (last_byte) begin
                // An option that ends with a field still owed gets an error.
                if (st.first_err == obp_pkg::ERR_NONE) begin
                    if (st.phase == obp_pkg::PH_PIV) begin
                        st.first_err = obp_pkg::ERR_PIV_SHORT;
                    end else if (st.phase == obp_pkg::PH_CLEN ||
                                 st.phase == obp_pkg::PH_CTX) begin
                        st.first_err = obp_pkg::ERR_CONTEXT;
                    end else if (st.phase == obp_pkg::PH_KID && st.kid_count == 8'd0) begin
                        st.first_err = obp_pkg::ERR_KEY_ID;
                    end
                end
                res.done    = 1'b1;
                res.status  = st.first_err;
                res.piv_len = st.flag_bits[2:0];
                res.ctx_len = st.ctx_len;
                res.kid_len = st.kid_count;
                res.seq     = st.seq;
                nxt_st      = obp_pkg::ST_RESET;
            end else begin
                nxt_st = st;
            end
        end
    end

endmodule

@@ src/secure_option_byte_parser_unit.sv @@
// Channel    | dir | tdata                        | tlast        | tuser
// s_ (bytes) | in  | data_byte                    | last_byte    | empty_option
// m_ (roles) | out | index, value, summary fields | option_done  | byte_role
//
// One item per cycle while m_tready stays high; an accepted item moves from the
// input register to the result register and then shows on m_.
// The parser state advances when an item leaves the input register.
// aresetn is synchronous, active low, and returns the parser to the flags byte.
// A stalled m_tready holds the result and, once the input register is full,
// drops s_tready.
// Top level of the option byte parser; depends on obp_pkg and obp_step.
module secure_option_byte_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    input  logic        s_tuser,   // [0] empty_option
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] role_index, [15:8] byte_value, [18:16] status, [21:19] piv_length,
    // [29:22] context_length, [37:30] key_id_length, [77:38] piv_seq,
    // [79:78] zero
    output logic [79:0] m_tdata,
    output logic        m_tlast,
    output logic [2:0]  m_tuser    // [2:0] byte_role
);

    logic             in_vld_reg;
    logic [7:0]       in_data_reg;
    logic             in_last_reg;
    logic             in_empty_reg;
    obp_pkg::state_t  st_reg;
    obp_pkg::state_t  st_next;
    obp_pkg::result_t res_reg;
    obp_pkg::result_t res_next;
    logic             out_vld_reg;
    logic             advance;

    assign advance  = !out_vld_reg || m_tready;
    assign s_tready = !in_vld_reg || advance;

    obp_step u_step (
        .cur_st       (st_reg),
        .data_byte    (in_data_reg),
        .last_byte    (in_last_reg),
        .empty_option (in_empty_reg),
        .nxt_st       (st_next),
        .res          (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            st_reg      <= obp_pkg::ST_RESET;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (advance) begin
                out_vld_reg <= in_vld_reg;
                if (in_vld_reg) begin
                    st_reg <= st_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg  <= s_tdata;
            in_last_reg  <= s_tlast;
            in_empty_reg <= s_tuser;
        end
        if (advance && in_vld_reg) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = res_reg.done;
    assign m_tuser  = res_reg.role;
    assign m_tdata  = {2'b00, res_reg.seq, res_reg.kid_len, res_reg.ctx_len,
                       res_reg.piv_len, res_reg.status, res_reg.value, res_reg.index};

endmodule

@@ src/obp_checker.sv @@
// Port-level checks for the option byte parser, bound to the top level.
// Depends on obp_pkg and secure_option_byte_parser_unit_defines.svh.
`include "secure_option_byte_parser_unit_defines.svh"

module obp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic        m_tlast,
    input logic [2:0]  m_tuser
);

    // A result that is not taken keeps its payload.
    `OBP_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // Summary fields are zero on every item that does not close an option.
    `OBP_ASSERT_IMP(a_summary_zero, aclk, aresetn, m_tvalid && !m_tlast, m_tdata[77:16] == 62'd0)

    // Roles and status codes stay within their defined ranges.
    `OBP_ASSERT_IMP(a_codes, aclk, aresetn, m_tvalid, m_tuser <= 3'(obp_pkg::ROLE_EXCESS) && m_tdata[18:16] <= 3'(obp_pkg::ERR_TRAILING))

    // Reset empties the pipeline.
    `OBP_ASSERT_RST(a_reset, aclk, aresetn, !m_tvalid && s_tready)

endmodule

bind secure_option_byte_parser_unit obp_checker u_obp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
